/* rtl/quad_isoparametric_geometry_top_assert.svh */
// Assertion macros shared by the quad isoparametric geometry RTL.
// Needs nothing else; include by bare file name inside a module body.
`ifndef QUAD_ISOPARAMETRIC_GEOMETRY_TOP_ASSERT_SVH
`define QUAD_ISOPARAMETRIC_GEOMETRY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QIG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qig_pkg.sv */
// Types, widths and helper functions of the quad isoparametric geometry block.
// Depends on nothing; imported by quad_isoparametric_geometry_top and its testbench.
package qig_pkg;

    localparam int ISO_W   = 26;   // iso terms, Q.14
    localparam int PM_W    = 28;   // 3*a +/- b terms
    localparam int PROD_W  = 56;   // weight products
    localparam int DIFF_W  = 58;   // weight product difference
    localparam int VPROD_W = 52;   // area products
    localparam int VDIFF_W = 53;   // area product difference
    localparam int WIDE_W  = 40;   // weights and area, Q.12
    localparam int QUO_W   = 48;   // biased dividend and quotient, six bytes
    localparam int STAGES  = 7;

    // Weight = round(n / (9 * 2^16)): add 9 * 2^15, shift right by 16, then floor divide by 9.
    localparam int                  WEIGHT_SHIFT = 16;
    localparam logic [DIFF_W-1:0]   WEIGHT_HALF  = DIFF_W'(294912);
    localparam int                  VOLUME_SHIFT = 14;
    localparam logic [VDIFF_W-1:0]  VOLUME_HALF  = VDIFF_W'(8192);

    // Top byte of the dividend after adding 9 * 2^40 to a 41-bit signed value.
    localparam logic [7:0]          BIAS_HI_POS  = 8'd9;
    localparam logic [7:0]          BIAS_HI_NEG  = 8'd8;
    localparam logic [QUO_W-1:0]    QUO_BIAS     = QUO_W'(1) << WIDE_W;
    localparam logic [QUO_W-1:0]    QUO_LIMIT    = QUO_W'(1) << (WIDE_W + 1);

    localparam logic [10:0]         DIV9_RECIP   = 11'd1821;
    localparam logic [11:0]         DIV9         = 12'd9;
    localparam logic [3:0]          DIV9_REM_MAX = 4'd9;

    typedef logic signed [ISO_W-1:0] t_iso;

    typedef struct packed {
        t_iso a1;
        t_iso a2;
        t_iso a3;
        t_iso b1;
        t_iso b2;
        t_iso b3;
    } t_iso_set;

    typedef struct packed {
        logic [7:0] q;
        logic [3:0] r;
    } t_div9;

    // One radix-256 digit of a long division by nine; rem is below nine.
    function automatic t_div9 div9_step(input logic [3:0] rem, input logic [7:0] digit);
        logic [11:0] v;
        logic [22:0] prod;
        logic [11:0] left;
        t_div9       res;
        v     = {rem, digit};
        prod  = {11'd0, v} * {12'd0, DIV9_RECIP};
        res.q = prod[21:14];
        left  = v - ({4'd0, res.q} * DIV9);
        res.r = left[3:0];
        return res;
    endfunction

    // Clamp a signed 48-bit value to the signed 40-bit range.
    function automatic logic [WIDE_W-1:0] sat_wide(input logic [QUO_W-1:0] v);
        logic [WIDE_W-1:0] res;
        if ((&v[QUO_W-1:WIDE_W-1]) || !(|v[QUO_W-1:WIDE_W-1])) begin
            res = v[WIDE_W-1:0];
        end else if (v[QUO_W-1]) begin
            res = {1'b1, {(WIDE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WIDE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* rtl/quad_isoparametric_geometry_top.sv */
// Bilinear quadrilateral isoparametric terms, corner weights and element area.
// Depends on qig_pkg and quad_isoparametric_geometry_top_assert.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one element: four corner x and
//   four corner y coordinates, signed Q11.12 at COORD_WIDTH bits.
//   Output channel (o_valid / i_ready) carries one result per element: the six
//   iso terms (Q.14), four corner weights and the area (Q.12, saturated to
//   40 bits) and a flag for an area below the configured floor.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the 40-bit area
//   floor; it is always ready and is meant to be written while the block idles.
// Timing:
//   Seven register stages: iso sums, 3a+/-b terms, products, difference and
//   rounding, two stages of byte-wise division by nine, saturation. One element
//   per cycle is sustained while the receiver is ready, set by the one product
//   per multiplier per stage.
// Reset clears all stage valid bits and sets the floor to zero.
// When the receiver stalls, each stage holds while its successor is full and
// empty stages keep filling, so up to seven elements are taken before o_ready
// falls.
module quad_isoparametric_geometry_top
    import qig_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_corner_x0,
    input  logic [COORD_WIDTH-1:0] i_corner_x1,
    input  logic [COORD_WIDTH-1:0] i_corner_x2,
    input  logic [COORD_WIDTH-1:0] i_corner_x3,
    input  logic [COORD_WIDTH-1:0] i_corner_y0,
    input  logic [COORD_WIDTH-1:0] i_corner_y1,
    input  logic [COORD_WIDTH-1:0] i_corner_y2,
    input  logic [COORD_WIDTH-1:0] i_corner_y3,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ISO_W-1:0]       o_dx_xi,
    output logic [ISO_W-1:0]       o_dx_cross,
    output logic [ISO_W-1:0]       o_dx_eta,
    output logic [ISO_W-1:0]       o_dy_xi,
    output logic [ISO_W-1:0]       o_dy_cross,
    output logic [ISO_W-1:0]       o_dy_eta,
    output logic [WIDE_W-1:0]      o_corner_weight0,
    output logic [WIDE_W-1:0]      o_corner_weight1,
    output logic [WIDE_W-1:0]      o_corner_weight2,
    output logic [WIDE_W-1:0]      o_corner_weight3,
    output logic [WIDE_W-1:0]      o_element_volume,
    output logic                   o_volume_negative,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [WIDE_W-1:0]      i_cfg_data
);

    localparam int PM_A1M = 0;
    localparam int PM_A1P = 1;
    localparam int PM_A3M = 2;
    localparam int PM_A3P = 3;
    localparam int PM_B1M = 4;
    localparam int PM_B1P = 5;
    localparam int PM_B3M = 6;
    localparam int PM_B3P = 7;

    logic [COORD_WIDTH-1:0]     w_cx [4];
    logic [COORD_WIDTH-1:0]     w_cy [4];
    t_iso                       w_x [4];
    t_iso                       w_y [4];
    logic [STAGES:0]            en;
    logic [STAGES-1:0]          r_v;
    logic [WIDE_W-1:0]          r_floor;

    // Stage 0: iso sums.
    t_iso_set                   n_s0_iso, r_s0_iso;
    // Stage 1: 3a +/- b terms.
    t_iso_set                   r_s1_iso;
    logic signed [PM_W-1:0]     n_s1_pm [8];
    logic signed [PM_W-1:0]     r_s1_pm [8];
    // Stage 2: products.
    t_iso_set                   r_s2_iso;
    logic signed [PROD_W-1:0]   n_s2_wp [8];
    logic signed [PROD_W-1:0]   r_s2_wp [8];
    logic signed [VPROD_W-1:0]  n_s2_vp [2];
    logic signed [VPROD_W-1:0]  r_s2_vp [2];
    // Stage 3: difference, rounding and biased dividend.
    t_iso_set                   r_s3_iso;
    logic [DIFF_W-1:0]          w_s3_d [4];
    logic [QUO_W-1:0]           n_s3_u [4];
    logic [QUO_W-1:0]           r_s3_u [4];
    logic [VDIFF_W-1:0]         w_s3_vd;
    logic [WIDE_W-1:0]          n_s3_vol, r_s3_vol;
    // Stage 4: upper three quotient bytes and the floor compare.
    t_iso_set                   r_s4_iso;
    logic [WIDE_W-1:0]          r_s4_vol;
    logic                       n_s4_neg, r_s4_neg;
    logic [23:0]                n_s4_qhi [4];
    logic [23:0]                r_s4_qhi [4];
    logic [3:0]                 n_s4_rem [4];
    logic [3:0]                 r_s4_rem [4];
    logic [23:0]                r_s4_ulo [4];
    // Stage 5: lower three quotient bytes.
    t_iso_set                   r_s5_iso;
    logic [WIDE_W-1:0]          r_s5_vol;
    logic                       r_s5_neg;
    logic [QUO_W-1:0]           n_s5_q [4];
    logic [QUO_W-1:0]           r_s5_q [4];
    // Stage 6: output register.
    t_iso_set                   r_s6_iso;
    logic [WIDE_W-1:0]          n_s6_w [4];
    logic [WIDE_W-1:0]          r_s6_w [4];
    logic [WIDE_W-1:0]          r_s6_vol;
    logic                       r_s6_neg;

    t_div9                      w_step4 [4][3];
    t_div9                      w_step5 [4][3];

    assign w_cx[0] = i_corner_x0;
    assign w_cx[1] = i_corner_x1;
    assign w_cx[2] = i_corner_x2;
    assign w_cx[3] = i_corner_x3;
    assign w_cy[0] = i_corner_y0;
    assign w_cy[1] = i_corner_y1;
    assign w_cy[2] = i_corner_y2;
    assign w_cy[3] = i_corner_y3;

    // The iso sums wrap to 26 bits, so wider coordinates only need their low bits.
    for (genvar g = 0; g < 4; g++) begin : g_coord
        if (COORD_WIDTH >= ISO_W) begin : g_trunc
            assign w_x[g] = w_cx[g][ISO_W-1:0];
            assign w_y[g] = w_cy[g][ISO_W-1:0];
        end else begin : g_sext
            assign w_x[g] = {{(ISO_W-COORD_WIDTH){w_cx[g][COORD_WIDTH-1]}}, w_cx[g]};
            assign w_y[g] = {{(ISO_W-COORD_WIDTH){w_cy[g][COORD_WIDTH-1]}}, w_cy[g]};
        end
    end

    // Each stage moves when it is empty or its successor moves.
    always_comb begin
        en[STAGES] = i_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready     = en[0];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_floor <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (i_cfg_valid) begin
                r_floor <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_s0_iso.a1 = w_x[1] + w_x[2] - w_x[0] - w_x[3];
        n_s0_iso.a2 = w_x[0] - w_x[1] + w_x[2] - w_x[3];
        n_s0_iso.a3 = w_x[2] + w_x[3] - w_x[0] - w_x[1];
        n_s0_iso.b1 = w_y[1] + w_y[2] - w_y[0] - w_y[3];
        n_s0_iso.b2 = w_y[0] - w_y[1] + w_y[2] - w_y[3];
        n_s0_iso.b3 = w_y[2] + w_y[3] - w_y[0] - w_y[1];
    end

    always_comb begin
        n_s1_pm[PM_A1M] = (PM_W'(r_s0_iso.a1) <<< 1) + PM_W'(r_s0_iso.a1) - PM_W'(r_s0_iso.a2);
        n_s1_pm[PM_A1P] = (PM_W'(r_s0_iso.a1) <<< 1) + PM_W'(r_s0_iso.a1) + PM_W'(r_s0_iso.a2);
        n_s1_pm[PM_A3M] = (PM_W'(r_s0_iso.a3) <<< 1) + PM_W'(r_s0_iso.a3) - PM_W'(r_s0_iso.a2);
        n_s1_pm[PM_A3P] = (PM_W'(r_s0_iso.a3) <<< 1) + PM_W'(r_s0_iso.a3) + PM_W'(r_s0_iso.a2);
        n_s1_pm[PM_B1M] = (PM_W'(r_s0_iso.b1) <<< 1) + PM_W'(r_s0_iso.b1) - PM_W'(r_s0_iso.b2);
        n_s1_pm[PM_B1P] = (PM_W'(r_s0_iso.b1) <<< 1) + PM_W'(r_s0_iso.b1) + PM_W'(r_s0_iso.b2);
        n_s1_pm[PM_B3M] = (PM_W'(r_s0_iso.b3) <<< 1) + PM_W'(r_s0_iso.b3) - PM_W'(r_s0_iso.b2);
        n_s1_pm[PM_B3P] = (PM_W'(r_s0_iso.b3) <<< 1) + PM_W'(r_s0_iso.b3) + PM_W'(r_s0_iso.b2);
    end

    // Products in pairs: entries 2k and 2k+1 are the two terms of weight k.
    always_comb begin
        n_s2_wp[0] = r_s1_pm[PM_B3M] * r_s1_pm[PM_A1M];
        n_s2_wp[1] = r_s1_pm[PM_A3M] * r_s1_pm[PM_B1M];
        n_s2_wp[2] = r_s1_pm[PM_B3P] * r_s1_pm[PM_A1M];
        n_s2_wp[3] = r_s1_pm[PM_A3P] * r_s1_pm[PM_B1M];
        n_s2_wp[4] = r_s1_pm[PM_B3P] * r_s1_pm[PM_A1P];
        n_s2_wp[5] = r_s1_pm[PM_A3P] * r_s1_pm[PM_B1P];
        n_s2_wp[6] = r_s1_pm[PM_B3M] * r_s1_pm[PM_A1P];
        n_s2_wp[7] = r_s1_pm[PM_A3M] * r_s1_pm[PM_B1P];
        n_s2_vp[0] = r_s1_iso.a1 * r_s1_iso.b3;
        n_s2_vp[1] = r_s1_iso.a3 * r_s1_iso.b1;
    end

    // Adding 9 * 2^40 makes the shifted value positive, so a plain unsigned
    // long division gives the floor quotient plus 2^40.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_s3_d[k] = DIFF_W'(r_s2_wp[2*k]) - DIFF_W'(r_s2_wp[2*k+1]) + WEIGHT_HALF;
            n_s3_u[k] = {(w_s3_d[k][WEIGHT_SHIFT+WIDE_W] ? BIAS_HI_NEG : BIAS_HI_POS),
                         w_s3_d[k][WEIGHT_SHIFT+WIDE_W-1:WEIGHT_SHIFT]};
        end
        w_s3_vd  = VDIFF_W'(r_s2_vp[0]) - VDIFF_W'(r_s2_vp[1]) + VOLUME_HALF;
        n_s3_vol = sat_wide(QUO_W'($signed(w_s3_vd[VDIFF_W-1:VOLUME_SHIFT])));
    end

    always_comb begin
        n_s4_neg = $signed(r_s3_vol) < $signed(r_floor);
        for (int k = 0; k < 4; k++) begin
            w_step4[k][0] = div9_step(4'd0, r_s3_u[k][47:40]);
            w_step4[k][1] = div9_step(w_step4[k][0].r, r_s3_u[k][39:32]);
            w_step4[k][2] = div9_step(w_step4[k][1].r, r_s3_u[k][31:24]);
            n_s4_qhi[k]   = {w_step4[k][0].q, w_step4[k][1].q, w_step4[k][2].q};
            n_s4_rem[k]   = w_step4[k][2].r;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_step5[k][0] = div9_step(r_s4_rem[k], r_s4_ulo[k][23:16]);
            w_step5[k][1] = div9_step(w_step5[k][0].r, r_s4_ulo[k][15:8]);
            w_step5[k][2] = div9_step(w_step5[k][1].r, r_s4_ulo[k][7:0]);
            n_s5_q[k]     = {r_s4_qhi[k], w_step5[k][0].q, w_step5[k][1].q, w_step5[k][2].q};
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_s6_w[k] = sat_wide(r_s5_q[k] - QUO_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_iso <= n_s0_iso;
        end
        if (en[1]) begin
            r_s1_iso <= r_s0_iso;
            r_s1_pm  <= n_s1_pm;
        end
        if (en[2]) begin
            r_s2_iso <= r_s1_iso;
            r_s2_wp  <= n_s2_wp;
            r_s2_vp  <= n_s2_vp;
        end
        if (en[3]) begin
            r_s3_iso <= r_s2_iso;
            r_s3_u   <= n_s3_u;
            r_s3_vol <= n_s3_vol;
        end
        if (en[4]) begin
            r_s4_iso <= r_s3_iso;
            r_s4_vol <= r_s3_vol;
            r_s4_neg <= n_s4_neg;
            r_s4_qhi <= n_s4_qhi;
            r_s4_rem <= n_s4_rem;
            for (int k = 0; k < 4; k++) begin
                r_s4_ulo[k] <= r_s3_u[k][23:0];
            end
        end
        if (en[5]) begin
            r_s5_iso <= r_s4_iso;
            r_s5_vol <= r_s4_vol;
            r_s5_neg <= r_s4_neg;
            r_s5_q   <= n_s5_q;
        end
        if (en[6]) begin
            r_s6_iso <= r_s5_iso;
            r_s6_w   <= n_s6_w;
            r_s6_vol <= r_s5_vol;
            r_s6_neg <= r_s5_neg;
        end
    end

    assign o_valid           = r_v[STAGES-1];
    assign o_dx_xi           = r_s6_iso.a1;
    assign o_dx_cross        = r_s6_iso.a2;
    assign o_dx_eta          = r_s6_iso.a3;
    assign o_dy_xi           = r_s6_iso.b1;
    assign o_dy_cross        = r_s6_iso.b2;
    assign o_dy_eta          = r_s6_iso.b3;
    assign o_corner_weight0  = r_s6_w[0];
    assign o_corner_weight1  = r_s6_w[1];
    assign o_corner_weight2  = r_s6_w[2];
    assign o_corner_weight3  = r_s6_w[3];
    assign o_element_volume  = r_s6_vol;
    assign o_volume_negative = r_s6_neg;

`include "quad_isoparametric_geometry_top_assert.svh"

    // An accepted transaction always lands in the first stage.
    `QIG_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_v[0], "accepted transaction lost at stage 0")

    // Partial remainders of the division by nine stay below nine.
    `QIG_ASSERT_IMPL(a_rem_below_nine, i_clk, i_rst_n, r_v[4], (r_s4_rem[0] < DIV9_REM_MAX) && (r_s4_rem[1] < DIV9_REM_MAX) && (r_s4_rem[2] < DIV9_REM_MAX) && (r_s4_rem[3] < DIV9_REM_MAX), "division remainder out of range")

    // The biased quotient is below 2^41, so removing the bias leaves 41 bits.
    `QIG_ASSERT_IMPL(a_quotient_range, i_clk, i_rst_n, r_v[5], (r_s5_q[0] < QUO_LIMIT) && (r_s5_q[1] < QUO_LIMIT) && (r_s5_q[2] < QUO_LIMIT) && (r_s5_q[3] < QUO_LIMIT), "weight quotient out of range")

endmodule

/* tb/tb_quad_isoparametric_geometry_top.sv */
// Self-checking testbench for quad_isoparametric_geometry_top: random and corner-case elements
// against a built-in bilinear geometry predictor, with bursty input, stalling output, floor updates.
// Depends on qig_pkg and the RTL top level only.
module tb_quad_isoparametric_geometry_top;
    import qig_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     COORD_W        = 24;
    localparam longint WEIGHT_DIVISOR = 589824;    // 9 * 2^16
    localparam longint AREA_DIVISOR   = 16384;     // 2^14
    localparam longint WIDE_MAX       = (longint'(1) << (WIDE_W - 1)) - 1;
    localparam longint WIDE_MIN       = -WIDE_MAX - 1;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     CYCLE_LIMIT    = 300000;
    localparam int     HOLD_AT        = 60;
    localparam int     HOLD_CYCLES    = 60;

    localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] C_MIN = 24'h800000;
    localparam logic [COORD_W-1:0] C_M1  = 24'hFFFFFF;

    localparam logic signed [WIDE_W-1:0] FLOOR_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] FLOOR_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [3:0][COORD_W-1:0] cx;
        logic [3:0][COORD_W-1:0] cy;
    } t_corner_set;

    typedef struct packed {
        logic [ISO_W-1:0]  dx_xi;
        logic [ISO_W-1:0]  dx_cross;
        logic [ISO_W-1:0]  dx_eta;
        logic [ISO_W-1:0]  dy_xi;
        logic [ISO_W-1:0]  dy_cross;
        logic [ISO_W-1:0]  dy_eta;
        logic [WIDE_W-1:0] weight0;
        logic [WIDE_W-1:0] weight1;
        logic [WIDE_W-1:0] weight2;
        logic [WIDE_W-1:0] weight3;
        logic [WIDE_W-1:0] volume;
        logic              negative;
    } t_geometry_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [COORD_W-1:0]  i_corner_x0 = '0;
    logic [COORD_W-1:0]  i_corner_x1 = '0;
    logic [COORD_W-1:0]  i_corner_x2 = '0;
    logic [COORD_W-1:0]  i_corner_x3 = '0;
    logic [COORD_W-1:0]  i_corner_y0 = '0;
    logic [COORD_W-1:0]  i_corner_y1 = '0;
    logic [COORD_W-1:0]  i_corner_y2 = '0;
    logic [COORD_W-1:0]  i_corner_y3 = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [ISO_W-1:0]    o_dx_xi;
    logic [ISO_W-1:0]    o_dx_cross;
    logic [ISO_W-1:0]    o_dx_eta;
    logic [ISO_W-1:0]    o_dy_xi;
    logic [ISO_W-1:0]    o_dy_cross;
    logic [ISO_W-1:0]    o_dy_eta;
    logic [WIDE_W-1:0]   o_corner_weight0;
    logic [WIDE_W-1:0]   o_corner_weight1;
    logic [WIDE_W-1:0]   o_corner_weight2;
    logic [WIDE_W-1:0]   o_corner_weight3;
    logic [WIDE_W-1:0]   o_element_volume;
    logic                o_volume_negative;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [WIDE_W-1:0]   i_cfg_data = '0;

    t_corner_set             pending_elements[$];
    t_geometry_result        expected_results[$];
    t_corner_set             drive_item = '0;
    t_corner_set             next_item;
    t_geometry_result        got_result;
    t_geometry_result        want_result;
    logic signed [WIDE_W-1:0] floor_model = '0;

    int  error_count = 0;
    int  result_count = 0;
    int  accepted_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  stall_mode = 0;
    int  pattern_left = 0;
    bit  sink_open;
    logic long_hold;

    quad_isoparametric_geometry_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_corner_x0       (i_corner_x0),
        .i_corner_x1       (i_corner_x1),
        .i_corner_x2       (i_corner_x2),
        .i_corner_x3       (i_corner_x3),
        .i_corner_y0       (i_corner_y0),
        .i_corner_y1       (i_corner_y1),
        .i_corner_y2       (i_corner_y2),
        .i_corner_y3       (i_corner_y3),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_dx_xi           (o_dx_xi),
        .o_dx_cross        (o_dx_cross),
        .o_dx_eta          (o_dx_eta),
        .o_dy_xi           (o_dy_xi),
        .o_dy_cross        (o_dy_cross),
        .o_dy_eta          (o_dy_eta),
        .o_corner_weight0  (o_corner_weight0),
        .o_corner_weight1  (o_corner_weight1),
        .o_corner_weight2  (o_corner_weight2),
        .o_corner_weight3  (o_corner_weight3),
        .o_element_volume  (o_element_volume),
        .o_volume_negative (o_volume_negative),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Rounds num / den to nearest with ties toward plus infinity; den is positive and even.
    function automatic longint round_half_up(input longint num, input longint den);
        longint biased;
        longint quo;
        biased = num + den / 2;
        quo = biased / den;
        if ((biased % den) != 0 && biased < 0) begin
            quo = quo - 1;
        end
        return quo;
    endfunction

    function automatic longint clamp_wide(input longint v);
        if (v > WIDE_MAX) begin
            return WIDE_MAX;
        end
        if (v < WIDE_MIN) begin
            return WIDE_MIN;
        end
        return v;
    endfunction

    function automatic logic [WIDE_W-1:0] corner_weight(input longint p, input longint q,
                                                       input longint r, input longint s);
        return WIDE_W'(clamp_wide(round_half_up(p * q - r * s, WEIGHT_DIVISOR)));
    endfunction

    function automatic t_geometry_result predict_geometry(input t_corner_set c,
                                                          input logic signed [WIDE_W-1:0] area_floor);
        longint x0, x1, x2, x3, y0, y1, y2, y3;
        t_iso   a1, a2, a3, b1, b2, b3;
        longint a1m, a1p, a3m, a3p, b1m, b1p, b3m, b3p;
        longint area;
        t_geometry_result r;
        x0 = longint'($signed(c.cx[0]));
        x1 = longint'($signed(c.cx[1]));
        x2 = longint'($signed(c.cx[2]));
        x3 = longint'($signed(c.cx[3]));
        y0 = longint'($signed(c.cy[0]));
        y1 = longint'($signed(c.cy[1]));
        y2 = longint'($signed(c.cy[2]));
        y3 = longint'($signed(c.cy[3]));
        a1 = t_iso'(-x0 + x1 + x2 - x3);
        a2 = t_iso'(x0 - x1 + x2 - x3);
        a3 = t_iso'(-x0 - x1 + x2 + x3);
        b1 = t_iso'(-y0 + y1 + y2 - y3);
        b2 = t_iso'(y0 - y1 + y2 - y3);
        b3 = t_iso'(-y0 - y1 + y2 + y3);
        a1m = 3 * longint'(a1) - longint'(a2);
        a1p = 3 * longint'(a1) + longint'(a2);
        a3m = 3 * longint'(a3) - longint'(a2);
        a3p = 3 * longint'(a3) + longint'(a2);
        b1m = 3 * longint'(b1) - longint'(b2);
        b1p = 3 * longint'(b1) + longint'(b2);
        b3m = 3 * longint'(b3) - longint'(b2);
        b3p = 3 * longint'(b3) + longint'(b2);
        area = clamp_wide(round_half_up(longint'(a1) * longint'(b3) - longint'(a3) * longint'(b1),
                                        AREA_DIVISOR));
        r.dx_xi    = a1;
        r.dx_cross = a2;
        r.dx_eta   = a3;
        r.dy_xi    = b1;
        r.dy_cross = b2;
        r.dy_eta   = b3;
        r.weight0  = corner_weight(b3m, a1m, a3m, b1m);
        r.weight1  = corner_weight(b3p, a1m, a3p, b1m);
        r.weight2  = corner_weight(b3p, a1p, a3p, b1p);
        r.weight3  = corner_weight(b3m, a1p, a3m, b1p);
        r.volume   = WIDE_W'(area);
        r.negative = (area < longint'(area_floor));
        return r;
    endfunction

    function automatic t_corner_set make_element(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] x1,
        input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] x3,
        input logic [COORD_W-1:0] y0, input logic [COORD_W-1:0] y1,
        input logic [COORD_W-1:0] y2, input logic [COORD_W-1:0] y3);
        t_corner_set c;
        c.cx[0] = x0;
        c.cx[1] = x1;
        c.cx[2] = x2;
        c.cx[3] = x3;
        c.cy[0] = y0;
        c.cy[1] = y1;
        c.cy[2] = y2;
        c.cy[3] = y3;
        return c;
    endfunction

    // Uniform integer in [-span, span].
    function automatic int signed_rand(input int span);
        int v;
        v = $urandom_range(0, 2 * span);
        return v - span;
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return C_MAX;
            1: return C_MIN;
            2: return C_M1;
            3: return 24'd1;
            default: return '0;
        endcase
    endfunction

    function automatic t_corner_set random_element();
        t_corner_set c;
        int kind;
        int base_x, base_y, w, h, k;
        logic [COORD_W-1:0] swap;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                for (k = 0; k < 4; k++) begin
                    c.cx[k] = COORD_W'($urandom);
                    c.cy[k] = COORD_W'($urandom);
                end
            end
            4, 5: begin
                for (k = 0; k < 4; k++) begin
                    c.cx[k] = COORD_W'(signed_rand(256));
                    c.cy[k] = COORD_W'(signed_rand(256));
                end
            end
            6: begin
                for (k = 0; k < 4; k++) begin
                    c.cx[k] = extreme_coord();
                    c.cy[k] = extreme_coord();
                end
            end
            default: begin
                // A plausible mesh element: a jittered rectangle, counterclockwise.
                base_x = signed_rand(2097152);
                base_y = signed_rand(2097152);
                w = $urandom_range(1, 2097152);
                h = $urandom_range(1, 2097152);
                c.cx[0] = COORD_W'(base_x + signed_rand(1024));
                c.cx[1] = COORD_W'(base_x + w + signed_rand(1024));
                c.cx[2] = COORD_W'(base_x + w + signed_rand(1024));
                c.cx[3] = COORD_W'(base_x + signed_rand(1024));
                c.cy[0] = COORD_W'(base_y + signed_rand(1024));
                c.cy[1] = COORD_W'(base_y + signed_rand(1024));
                c.cy[2] = COORD_W'(base_y + h + signed_rand(1024));
                c.cy[3] = COORD_W'(base_y + h + signed_rand(1024));
                // Swapping corners 1 and 3 turns the element inside out.
                if (kind == 9) begin
                    swap = c.cx[1];
                    c.cx[1] = c.cx[3];
                    c.cx[3] = swap;
                    swap = c.cy[1];
                    c.cy[1] = c.cy[3];
                    c.cy[3] = swap;
                end
            end
        endcase
        return c;
    endfunction

    task automatic queue_random_elements(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            pending_elements.push_back(random_element());
        end
    endtask

    task automatic write_area_floor(input logic signed [WIDE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        floor_model = value;
    endtask

    // Checked at the falling edge, when the driver's updates of the rising edge have settled.
    task automatic wait_drained();
        while (pending_elements.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10) begin
                $display("element %0d %s: expected %h, got %h", result_count, label, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_quad_isoparametric_geometry_top: FAIL");
            $finish;
        end
    end

    // Input driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_geometry(drive_item, floor_model));
                accepted_count <= accepted_count + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 && !long_hold) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_elements.size() != 0) begin
                    next_item = pending_elements.pop_front();
                    drive_item  <= next_item;
                    i_corner_x0 <= next_item.cx[0];
                    i_corner_x1 <= next_item.cx[1];
                    i_corner_x2 <= next_item.cx[2];
                    i_corner_x3 <= next_item.cx[3];
                    i_corner_y0 <= next_item.cy[0];
                    i_corner_y1 <= next_item.cy[1];
                    i_corner_y2 <= next_item.cy[2];
                    i_corner_y3 <= next_item.cy[3];
                    i_valid     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        if ($urandom_range(0, 2) == 0) begin
                            gap_left <= 0;
                        end else if ($urandom_range(0, 9) == 0) begin
                            gap_left <= $urandom_range(15, 40);
                        end else begin
                            gap_left <= $urandom_range(1, 6);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off so the pipeline fills and backpressures the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    assign long_hold = (hold_left != 0);

    // Output monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready      <= 1'b0;
            pattern_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got_result = {o_dx_xi, o_dx_cross, o_dx_eta, o_dy_xi, o_dy_cross, o_dy_eta,
                              o_corner_weight0, o_corner_weight1, o_corner_weight2,
                              o_corner_weight3, o_element_volume, o_volume_negative};
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("element %0d: result with no element outstanding", result_count);
                    end
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("dx_xi", want_result.dx_xi, got_result.dx_xi);
                    check_field("dx_cross", want_result.dx_cross, got_result.dx_cross);
                    check_field("dx_eta", want_result.dx_eta, got_result.dx_eta);
                    check_field("dy_xi", want_result.dy_xi, got_result.dy_xi);
                    check_field("dy_cross", want_result.dy_cross, got_result.dy_cross);
                    check_field("dy_eta", want_result.dy_eta, got_result.dy_eta);
                    check_field("corner_weight0", want_result.weight0, got_result.weight0);
                    check_field("corner_weight1", want_result.weight1, got_result.weight1);
                    check_field("corner_weight2", want_result.weight2, got_result.weight2);
                    check_field("corner_weight3", want_result.weight3, got_result.weight3);
                    check_field("element_volume", want_result.volume, got_result.volume);
                    check_field("volume_negative", want_result.negative, got_result.negative);
                end
                result_count <= result_count + 1;
            end
            if (pattern_left == 0) begin
                stall_mode   <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(30, 150);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (stall_mode)
                0:       sink_open = 1'b1;
                1:       sink_open = ($urandom_range(0, 3) != 0);
                2:       sink_open = ($urandom_range(0, 3) == 0);
                default: sink_open = ((cycle_count % 5) != 0);
            endcase
            i_ready <= sink_open && !long_hold;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_area_floor('0);
        pending_elements.push_back(make_element('0, '0, '0, '0, '0, '0, '0, '0));
        pending_elements.push_back(make_element(C_MAX, C_MAX, C_MAX, C_MAX,
                                                C_MAX, C_MAX, C_MAX, C_MAX));
        pending_elements.push_back(make_element(C_MIN, C_MIN, C_MIN, C_MIN,
                                                C_MIN, C_MIN, C_MIN, C_MIN));
        pending_elements.push_back(make_element(C_MAX, C_MAX, C_MAX, C_MAX,
                                                C_MIN, C_MIN, C_MIN, C_MIN));
        // Largest positive and negative iso terms along both axes.
        pending_elements.push_back(make_element(C_MIN, C_MAX, C_MAX, C_MIN,
                                                C_MIN, C_MIN, C_MAX, C_MAX));
        pending_elements.push_back(make_element(C_MAX, C_MIN, C_MIN, C_MAX,
                                                C_MAX, C_MAX, C_MIN, C_MIN));
        pending_elements.push_back(make_element(C_MAX, C_MIN, C_MAX, C_MIN,
                                                C_MIN, C_MAX, C_MIN, C_MAX));
        pending_elements.push_back(make_element(C_MAX, C_MIN, C_MIN, C_MIN,
                                                C_MIN, C_MIN, C_MAX, C_MIN));
        // Unit square in both orientations, then a collapsed point and a line.
        pending_elements.push_back(make_element('0, 24'h1000, 24'h1000, '0,
                                                '0, '0, 24'h1000, 24'h1000));
        pending_elements.push_back(make_element('0, '0, 24'h1000, 24'h1000,
                                                '0, 24'h1000, 24'h1000, '0));
        pending_elements.push_back(make_element(24'h123456, 24'h123456, 24'h123456, 24'h123456,
                                                24'hFEDCBA, 24'hFEDCBA, 24'hFEDCBA, 24'hFEDCBA));
        pending_elements.push_back(make_element('0, 24'h1000, 24'h2000, 24'h3000,
                                                '0, 24'h1000, 24'h2000, 24'h3000));
        // Area exactly halfway between two steps, positive and negative.
        pending_elements.push_back(make_element('0, 24'd1, '0, '0, '0, '0, 24'h1000, 24'h1000));
        pending_elements.push_back(make_element('0, C_M1, '0, '0, '0, '0, 24'h1000, 24'h1000));
        // Corner weights 0 and 1 exactly halfway between two steps, positive and negative.
        pending_elements.push_back(make_element('0, 24'd1, '0, '0, '0, '0, 24'h3000, 24'h3000));
        pending_elements.push_back(make_element('0, C_M1, '0, '0, '0, '0, 24'h3000, 24'h3000));
        pending_elements.push_back(make_element(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                                                24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        queue_random_elements(40);
        wait_drained();

        write_area_floor(FLOOR_MAX);
        queue_random_elements(90);
        wait_drained();

        write_area_floor(FLOOR_MIN);
        queue_random_elements(70);
        wait_drained();

        write_area_floor(WIDE_W'((longint'($urandom) << 3) - (longint'(1) << 34)));
        queue_random_elements(80);
        wait_drained();

        write_area_floor(-40'sd1);
        queue_random_elements(60);
        wait_drained();

        write_area_floor(WIDE_W'(signed_rand(1048576)));
        queue_random_elements(60);
        wait_drained();

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_quad_isoparametric_geometry_top: PASS");
        end else begin
            $display("tb_quad_isoparametric_geometry_top: FAIL");
        end
        $finish;
    end

endmodule
